// ===== rtl/kbf_pkg.sv =====
// ----------------------------------------------------------------------------
// kbf_pkg: shared constants and helpers for the key bloom filter builder
// Hash constants, default sizes and small bit helpers used by several files.
// ----------------------------------------------------------------------------
package kbf_pkg;

   localparam int DEF_FILTER_BITS = 8192;
   localparam int DEF_HASH_COUNT  = 8;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
   localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
   localparam logic [63:0] FMIX_1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] MIX_A  = 64'h0000000052dce729;
   localparam logic [63:0] MIX_B  = 64'h0000000038495ab5;

   // tail of the 33-byte message is the single byte 0x01, so its k1 is constant
   localparam logic [63:0] TAIL_K1 = 64'({MM_C1[32:0], MM_C1[63:33]} * MM_C2);

   localparam logic [63:0] LEN_SHORT = 64'd32;
   localparam logic [63:0] LEN_LONG  = 64'd33;

   function automatic logic [6:0] lzc64(input logic [63:0] w);
      logic [6:0] n;
      n = 7'd64;
      for (int b = 0; b < 64; b++) begin
         if (w[b]) begin
            n = 7'(63 - b);
         end
      end
      return n;
   endfunction

   function automatic logic [63:0] bswap64(input logic [63:0] w);
      logic [63:0] r;
      for (int b = 0; b < 8; b++) begin
         r[8*b +: 8] = w[56-8*b +: 8];
      end
      return r;
   endfunction

endpackage

// ===== rtl/kbf_if.sv =====
// ----------------------------------------------------------------------------
// kbf channel interfaces
// Key request channel and filter word response channel, valid/ready.
// ----------------------------------------------------------------------------
interface kbf_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] key_word0;
   logic [63:0] key_word1;
   logic [63:0] key_word2;
   logic [63:0] key_word3;

   modport source (output valid, key_word0, key_word1, key_word2, key_word3, input ready);
   modport sink   (input valid, key_word0, key_word1, key_word2, key_word3, output ready);
endinterface

interface kbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_word;
   logic        is_last;

   modport source (output valid, out_word, is_last, input ready);
   modport sink   (input valid, out_word, is_last, output ready);
endinterface

// ===== rtl/kbf_mul.sv =====
// ----------------------------------------------------------------------------
// kbf_mul: 64x64 multiply by a constant, low 64 bits, two stages
// Stage one forms three 32x32 partial products, stage two sums them.
// ----------------------------------------------------------------------------
module kbf_mul
   import kbf_pkg::*;
#(
   parameter logic [63:0] FACTOR = MM_C1
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   output logic [63:0] y
);

   logic [63:0] p0_ff;
   logic [31:0] p1_ff;
   logic [31:0] p2_ff;
   logic [63:0] y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= a[31:0] * FACTOR[31:0];
         p1_ff <= 32'(a[63:32] * FACTOR[31:0]);
         p2_ff <= 32'(a[31:0] * FACTOR[63:32]);
         y_ff  <= p0_ff + {p1_ff + p2_ff, 32'd0};
      end
   end

   assign y = y_ff;

endmodule

// ===== rtl/kbf_front.sv =====
// ----------------------------------------------------------------------------
// kbf_front: partial key, double murmur hash and filter bit positions
// Fully pipelined, one key per cycle; the whole pipe holds while the
// position queue is full.
// ----------------------------------------------------------------------------
module kbf_front
   import kbf_pkg::*;
#(
   parameter int FILTER_BITS = DEF_FILTER_BITS,
   parameter int HASH_COUNT  = DEF_HASH_COUNT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   kbf_req_if.sink                                 req_chan,
   output logic                                    pos_valid,
   input  logic                                    pos_ready,
   output logic [HASH_COUNT-1:0][$clog2(FILTER_BITS)-1:0] pos_data
);

   localparam int POS_W = $clog2(FILTER_BITS);
   localparam int MW    = POS_W + 8;
   localparam int NST   = 31;

   typedef struct packed {
      logic [63:0]      h1;
      logic [63:0]      h2;
      logic [3:0][63:0] k;
   } hst_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] times5(input logic [63:0] x, input logic [63:0] c);
      return x + (x << 2) + c;
   endfunction

   function automatic logic [63:0] xsh(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

   // small constant multiple by shifts and adds, wraps at 64 bits
   function automatic logic [63:0] scale(input logic [63:0] x, input logic [2:0] n);
      return (n[0] ? x : 64'd0) + (n[1] ? (x << 1) : 64'd0) + (n[2] ? (x << 2) : 64'd0);
   endfunction

   function automatic logic [POS_W-1:0] mod_reduce(input logic [MW-1:0] t_in);
      logic [MW-1:0] t;
      t = t_in;
      for (int k = 7; k >= 0; k--) begin
         if (t >= (MW'(FILTER_BITS) << k)) begin
            t = t - (MW'(FILTER_BITS) << k);
         end
      end
      return t[POS_W-1:0];
   endfunction

   logic                   adv;
   logic [NST-1:0]         v_ff;
   logic [3:0][63:0]       key_ff;
   logic [3:0][6:0]        lz_ff;
   logic [3:0][63:0]       kin_ff;
   logic [3:0][63:0]       ma;
   logic [3:0][63:0]       mb;
   hst_type                hs_ff [8];
   logic [3:0][63:0]       fa_ff;
   logic [3:0][63:0]       fb_ff;
   logic [3:0][63:0]       mc;
   logic [3:0][63:0]       md;
   logic [3:0][63:0]       fc_ff;
   logic [3:0][63:0]       fd_ff;
   logic [HASH_COUNT-1:0][63:0]      hsum;
   logic [HASH_COUNT-1:0][63:0]      hm_ff [8];
   logic [HASH_COUNT-1:0][POS_W-1:0] rm_ff [8];

   logic [8:0]             lead;
   logic [9:0]             kp;
   logic [9:0]             keep_n;
   logic [3:0][63:0]       pkey;

   // the pipe moves unless a finished item is stuck at the end
   assign adv           = !v_ff[NST-1] || pos_ready;
   assign req_chan.ready = adv;
   assign pos_valid     = v_ff[NST-1];
   assign pos_data      = rm_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], req_chan.valid};
      end
   end

   // leading zero count of the whole key, then the partial key
   always_comb begin
      if (lz_ff[0] != 7'd64) begin
         lead = 9'(lz_ff[0]);
      end else if (lz_ff[1] != 7'd64) begin
         lead = 9'd64 + 9'(lz_ff[1]);
      end else if (lz_ff[2] != 7'd64) begin
         lead = 9'd128 + 9'(lz_ff[2]);
      end else begin
         lead = 9'd192 + 9'(lz_ff[3]);
      end
      kp     = 10'(lead) + 10'd49;
      keep_n = '0;
      for (int j = 0; j < 4; j++) begin
         pkey[j] = key_ff[j];
         if (kp <= 10'(64 * j)) begin
            pkey[j] = '1;
         end else begin
            keep_n = kp - 10'(64 * j);
            if (keep_n < 10'd64) begin
               pkey[j] = key_ff[j] | ({64{1'b1}} >> keep_n[5:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         key_ff <= {req_chan.key_word3, req_chan.key_word2,
                    req_chan.key_word1, req_chan.key_word0};
         lz_ff  <= {lzc64(req_chan.key_word3), lzc64(req_chan.key_word2),
                    lzc64(req_chan.key_word1), lzc64(req_chan.key_word0)};
         for (int j = 0; j < 4; j++) begin
            kin_ff[j] <= bswap64(pkey[j]);
         end
      end
   end

   // k1 lanes (0, 2) and k2 lanes (1, 3) of both 16-byte blocks
   for (genvar l = 0; l < 4; l++) begin : g_kmul
      localparam logic [63:0] F1 = (l % 2 == 0) ? MM_C1 : MM_C2;
      localparam logic [63:0] F2 = (l % 2 == 0) ? MM_C2 : MM_C1;
      localparam int          RT = (l % 2 == 0) ? 31 : 33;

      kbf_mul #(.FACTOR(F1)) u_mul_a (
         .clock (clock),
         .en    (adv),
         .a     (kin_ff[l]),
         .y     (ma[l])
      );

      kbf_mul #(.FACTOR(F2)) u_mul_b (
         .clock (clock),
         .en    (adv),
         .a     (rotl(ma[l], RT)),
         .y     (mb[l])
      );
   end

   // block mixing, one mixing step per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         hs_ff[0].k  <= mb;
         hs_ff[0].h1 <= rotl(mb[0], 27);
         hs_ff[0].h2 <= '0;

         hs_ff[1].k  <= hs_ff[0].k;
         hs_ff[1].h2 <= hs_ff[0].h2;
         hs_ff[1].h1 <= times5(hs_ff[0].h1, MIX_A);

         hs_ff[2].k  <= hs_ff[1].k;
         hs_ff[2].h1 <= hs_ff[1].h1;
         hs_ff[2].h2 <= rotl(hs_ff[1].h2 ^ hs_ff[1].k[1], 31) + hs_ff[1].h1;

         hs_ff[3].k  <= hs_ff[2].k;
         hs_ff[3].h1 <= hs_ff[2].h1;
         hs_ff[3].h2 <= times5(hs_ff[2].h2, MIX_B);

         hs_ff[4].k  <= hs_ff[3].k;
         hs_ff[4].h2 <= hs_ff[3].h2;
         hs_ff[4].h1 <= rotl(hs_ff[3].h1 ^ hs_ff[3].k[2], 27) + hs_ff[3].h2;

         hs_ff[5].k  <= hs_ff[4].k;
         hs_ff[5].h2 <= hs_ff[4].h2;
         hs_ff[5].h1 <= times5(hs_ff[4].h1, MIX_A);

         hs_ff[6].k  <= hs_ff[5].k;
         hs_ff[6].h1 <= hs_ff[5].h1;
         hs_ff[6].h2 <= rotl(hs_ff[5].h2 ^ hs_ff[5].k[3], 31) + hs_ff[5].h1;

         hs_ff[7].k  <= hs_ff[6].k;
         hs_ff[7].h1 <= hs_ff[6].h1;
         hs_ff[7].h2 <= times5(hs_ff[6].h2, MIX_B);

         // lanes 0,1: 32-byte message; lanes 2,3: with the appended byte
         fa_ff[0] <= (hs_ff[7].h1 ^ LEN_SHORT) + (hs_ff[7].h2 ^ LEN_SHORT);
         fa_ff[1] <= hs_ff[7].h2 ^ LEN_SHORT;
         fa_ff[2] <= (hs_ff[7].h1 ^ TAIL_K1 ^ LEN_LONG) + (hs_ff[7].h2 ^ LEN_LONG);
         fa_ff[3] <= hs_ff[7].h2 ^ LEN_LONG;

         fb_ff[0] <= fa_ff[0];
         fb_ff[1] <= fa_ff[1] + fa_ff[0];
         fb_ff[2] <= fa_ff[2];
         fb_ff[3] <= fa_ff[3] + fa_ff[2];
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_fmix
      kbf_mul #(.FACTOR(FMIX_1)) u_mul_c (
         .clock (clock),
         .en    (adv),
         .a     (xsh(fb_ff[l])),
         .y     (mc[l])
      );

      kbf_mul #(.FACTOR(FMIX_2)) u_mul_d (
         .clock (clock),
         .en    (adv),
         .a     (xsh(mc[l])),
         .y     (md[l])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fc_ff[0] <= xsh(md[0]) + xsh(md[1]);
         fc_ff[1] <= xsh(md[1]);
         fc_ff[2] <= xsh(md[2]) + xsh(md[3]);
         fc_ff[3] <= xsh(md[3]);

         fd_ff[0] <= fc_ff[0];
         fd_ff[1] <= fc_ff[1] + fc_ff[0];
         fd_ff[2] <= fc_ff[2];
         fd_ff[3] <= fc_ff[3] + fc_ff[2];
      end
   end

   // position sums, wrapped at 64 bits like the hash words
   always_comb begin
      for (int i = 0; i < HASH_COUNT; i++) begin
         hsum[i] = fd_ff[i % 2] + scale(fd_ff[2 + (((i + (i % 2)) % 4) / 2)], 3'(i));
      end
   end

   // remainder of each position sum, one byte per stage, most significant first
   always_ff @(posedge clock) begin
      if (adv) begin
         hm_ff[0] <= hsum;
         for (int i = 0; i < HASH_COUNT; i++) begin
            rm_ff[0][i] <= mod_reduce(MW'(hm_ff[0][i][63:56]));
         end
         for (int s = 1; s < 8; s++) begin
            hm_ff[s] <= hm_ff[s-1];
            for (int i = 0; i < HASH_COUNT; i++) begin
               rm_ff[s][i] <= mod_reduce({rm_ff[s-1][i], hm_ff[s][i][63-8*s -: 8]});
            end
         end
      end
   end

endmodule

// ===== rtl/kbf_queue.sv =====
// ----------------------------------------------------------------------------
// kbf_queue: short register queue between the hash front and the emitter
// Power-of-two depth, first in first out.
// ----------------------------------------------------------------------------
module kbf_queue
   import kbf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff;
   logic [AW-1:0]    rd_ff;
   logic [CW-1:0]    count_ff;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= AW'(wr_ff + 1'b1);
         end
         if (pop) begin
            rd_ff <= AW'(rd_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/kbf_emit.sv =====
// ----------------------------------------------------------------------------
// kbf_emit: serializes one key's filter from its bit positions
// Zero-block flags, all-ones flags, then the hit blocks in ascending order.
// ----------------------------------------------------------------------------
module kbf_emit
   import kbf_pkg::*;
#(
   parameter int FILTER_BITS = DEF_FILTER_BITS,
   parameter int HASH_COUNT  = DEF_HASH_COUNT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   output logic                                    q_pop,
   input  logic [HASH_COUNT-1:0][$clog2(FILTER_BITS)-1:0] q_data,
   kbf_rsp_if.source                               rsp_chan
);

   localparam int POS_W   = $clog2(FILTER_BITS);
   localparam int BW      = POS_W - 6;
   localparam int NBLOCKS = (FILTER_BITS + 63) / 64;
   localparam int NFLAGW  = (NBLOCKS + 63) / 64;
   localparam int IDX_W   = $clog2(2 * NFLAGW + 1);
   localparam logic [IDX_W-1:0] MIX_IDX = IDX_W'(2 * NFLAGW);

   logic                              busy_ff;
   logic [IDX_W-1:0]                  idx_ff;
   logic [HASH_COUNT-1:0]             rem_ff;
   logic [HASH_COUNT-1:0][POS_W-1:0]  pos_ff;
   logic                              rsp_valid_ff;
   logic [63:0]                       rsp_word_ff;
   logic                              rsp_last_ff;

   logic                              out_free;
   logic                              step;
   logic                              mixed;
   logic [63:0]                       word;
   logic                              last;
   logic [HASH_COUNT-1:0]             match;
   logic [BW-1:0]                     mn;
   logic                              found;
   logic [7:0]                        bn;
   logic [7:0]                        base;
   logic                              hit;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step     = busy_ff && out_free;
   assign mixed    = (idx_ff == MIX_IDX);
   assign q_pop    = q_valid && (!busy_ff || (step && last));

   always_comb begin
      word  = '0;
      match = '0;
      mn    = '0;
      found = 1'b0;
      bn    = '0;
      hit   = 1'b0;
      base  = (idx_ff == '0) ? 8'd0 : 8'd64;
      if (idx_ff < IDX_W'(NFLAGW)) begin
         for (int k = 0; k < 64; k++) begin
            bn  = base + 8'(k);
            hit = 1'b0;
            for (int i = 0; i < HASH_COUNT; i++) begin
               if (8'(pos_ff[i][POS_W-1:6]) == bn) begin
                  hit = 1'b1;
               end
            end
            word[63-k] = (bn < 8'(NBLOCKS)) && !hit;
         end
      end else if (mixed) begin
         // lowest block still pending, then every bit that falls in it
         for (int i = 0; i < HASH_COUNT; i++) begin
            if (rem_ff[i] && (!found || pos_ff[i][POS_W-1:6] < mn)) begin
               mn    = pos_ff[i][POS_W-1:6];
               found = 1'b1;
            end
         end
         for (int i = 0; i < HASH_COUNT; i++) begin
            if (rem_ff[i] && pos_ff[i][POS_W-1:6] == mn) begin
               match[i] = 1'b1;
               word     = word | (64'd1 << pos_ff[i][5:0]);
            end
         end
      end
      // too few set bits to ever fill a block, so the ones mask stays zero
      last = mixed && ((rem_ff & ~match) == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= step;
         end
         if (step) begin
            rsp_word_ff <= word;
            rsp_last_ff <= last;
         end
         if (q_pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
            rem_ff  <= '1;
            pos_ff  <= q_data;
         end else if (step) begin
            if (mixed) begin
               rem_ff <= rem_ff & ~match;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_word = rsp_word_ff;
   assign rsp_chan.is_last  = rsp_last_ff;

   a_mixed_pending: assert property (@(posedge clock) disable iff (reset)
      busy_ff && mixed |-> rem_ff != '0)
      else $error("mixed phase with no pending block");

   a_last_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_word_ff != '0)
      else $error("final word carries no set bit");

   a_load_fresh: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> busy_ff && idx_ff == '0 && rem_ff == '1)
      else $error("new key not loaded cleanly");

endmodule

// ===== rtl/key_bloom_filter_builder.sv =====
// ----------------------------------------------------------------------------
// key_bloom_filter_builder: bloom filter of a public key, serialized
// Partial key, double murmur3 x64_128, HASH_COUNT bits in the filter, then
// zero flags, ones flags and mixed blocks as 64-bit words.
//
//   channel   dir  transaction
//   req_chan  in   one 256-bit key (key_word0..key_word3)
//   rsp_chan  out  one 64-bit filter word, is_last on the final one
//
// The hash front is a 31-stage pipeline taking one key per cycle unless held.
// The emitter sends one word per cycle while rsp_chan is ready: 2*ceil(blocks/64)
// flag words plus one per hit block, up to 12 with the defaults, which sets the key rate.
// A two-entry queue parts front and emitter; the front holds when it fills.
// Reset is synchronous and clears only control state; no clearing pass.
// ----------------------------------------------------------------------------
module key_bloom_filter_builder
   import kbf_pkg::*;
#(
   parameter int FILTER_BITS = DEF_FILTER_BITS,
   parameter int HASH_COUNT  = DEF_HASH_COUNT
) (
   input  logic       clock,
   input  logic       reset,
   kbf_req_if.sink    req_chan,
   kbf_rsp_if.source  rsp_chan
);

   localparam int POS_W = $clog2(FILTER_BITS);

   logic                              f_valid;
   logic                              f_ready;
   logic [HASH_COUNT-1:0][POS_W-1:0]  f_data;
   logic                              q_valid;
   logic                              q_pop;
   logic [HASH_COUNT*POS_W-1:0]       q_data;

   kbf_front #(
      .FILTER_BITS (FILTER_BITS),
      .HASH_COUNT  (HASH_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .pos_valid (f_valid),
      .pos_ready (f_ready),
      .pos_data  (f_data)
   );

   kbf_queue #(
      .WIDTH (HASH_COUNT * POS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_data)
   );

   kbf_emit #(
      .FILTER_BITS (FILTER_BITS),
      .HASH_COUNT  (HASH_COUNT)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_data   (q_data),
      .rsp_chan (rsp_chan)
   );

endmodule
